[rtl/core/wtd_pkg.sv]
// Shared field widths and codes of the weighted tree diameter block.
package wtd_pkg;

  localparam int MODE_W   = 1;
  localparam int NODE_W   = 12;
  localparam int WEIGHT_W = 16;
  localparam int DIAM_W   = 32;
  localparam int STATUS_W = 1;
  localparam int COUNT_W  = 13;

  localparam logic [MODE_W-1:0] MODE_ADD    = 1'b0;
  localparam logic [MODE_W-1:0] MODE_FINISH = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 1'b0;
  localparam logic [STATUS_W-1:0] STATUS_DROPPED = 1'b1;

endpackage

[rtl/core/wtd_if.sv]
// Valid/ready channel interfaces for edge items, results and configuration.
interface wtd_item_if;
  logic                          valid;
  logic                          ready;
  logic [wtd_pkg::MODE_W-1:0]    mode;
  logic [wtd_pkg::NODE_W-1:0]    node_a;
  logic [wtd_pkg::NODE_W-1:0]    node_b;
  logic [wtd_pkg::WEIGHT_W-1:0]  weight;
  modport source(output valid, mode, node_a, node_b, weight, input ready);
  modport sink(input valid, mode, node_a, node_b, weight, output ready);
endinterface

interface wtd_result_if;
  logic                          valid;
  logic                          ready;
  logic [wtd_pkg::DIAM_W-1:0]    diameter;
  logic [wtd_pkg::STATUS_W-1:0]  status;
  modport source(output valid, diameter, status, input ready);
  modport sink(input valid, diameter, status, output ready);
endinterface

interface wtd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [wtd_pkg::COUNT_W-1:0]   data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

[rtl/core/weighted_tree_diameter.sv]
// Top level: edge loading and depth-first diameter search over two node/edge memories.
//
// The block loads the undirected edges of a weighted tree, one per transfer on item,
// and on a finish transfer walks the tree from node 0 and returns the diameter on
// result. An edge is accepted in S_IDLE, then each of its two adjacency entries
// gets a read-modify-write in S_ADD_WR and S_ADD_LINK, all through the single
// port of the node memory. A finish enters node 0 in S_ROOT_WR; each adjacency entry
// is read in S_STEP and S_EDGE, skipped if it points outside node_count, else checked
// in S_CHK: skipped if visited, else opened in S_PUSH; S_POP returns to the parent. After
// reset, and after every result, a clearing pass writes each of the MAX_NODES node
// entries once, one per cycle, during which no item is accepted. Configuration
// transfers are taken at any time.
module weighted_tree_diameter #(
  parameter int MAX_NODES   = 4096,
  parameter int WEIGHT_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  wtd_item_if.sink     item,
  wtd_result_if.source result,
  wtd_cfg_if.sink      cfg
);

  localparam int NW       = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
  localparam int EDGE_CAP = 2 * (MAX_NODES - 1);
  localparam int EW       = (EDGE_CAP > 2) ? $clog2(EDGE_CAP) : 1;
  localparam int WS       = (WEIGHT_BITS < wtd_pkg::WEIGHT_W) ? WEIGHT_BITS
                                                               : wtd_pkg::WEIGHT_W;
  localparam int DW       = NW + WS + 1;
  localparam logic [NW-1:0] LAST_NODE = NW'(MAX_NODES - 1);

  typedef struct packed {
    logic          hv;
    logic [EW-1:0] head;
    logic [EW-1:0] tail;
    logic          vis;
    logic          pv;
    logic [NW-1:0] parent;
    logic [WS-1:0] upw;
    logic [DW-1:0] fr;
    logic [DW-1:0] hi;
    logic [DW-1:0] lo;
    logic [DW-1:0] climb;
    logic          cv;
    logic [EW-1:0] cursor;
  } node_rec_t;

  typedef struct packed {
    logic [NW-1:0] node;
    logic [WS-1:0] w;
    logic          lv;
    logic [EW-1:0] link;
  } edge_rec_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_ADD_WR, S_ADD_LINK, S_ROOT_WR, S_STEP, S_EDGE, S_CHK, S_PUSH, S_POP
  } state_t;

  node_rec_t nmem [MAX_NODES];
  edge_rec_t emem [EDGE_CAP];

  state_t        state;
  node_rec_t     nrd;
  edge_rec_t     erd;
  node_rec_t     cur;
  logic [NW-1:0] v;
  logic [NW-1:0] clr_idx;
  logic [EW:0]   edge_total;
  logic          ovf;
  logic [DW-1:0] best;
  logic [NW-1:0] add_a;
  logic [NW-1:0] add_b;
  logic [WS-1:0] add_w;
  logic          side;
  logic          old_hv;
  logic [EW-1:0] old_tail;
  logic [NW-1:0] eu;
  logic [WS-1:0] ew;
  logic          elv;
  logic [EW-1:0] elink;
  logic [wtd_pkg::COUNT_W-1:0] node_count;
  logic          out_valid;

  logic [31:0]   a32, b32, w32, nc32, n32;
  logic [NW-1:0] a_id, b_id, from_id, to_id;
  logic          add_drop, add_full;
  logic [DW-1:0] pair_sum, best_next, up_len;
  logic [63:0]   best64;
  node_rec_t     add_rec, pop_rec, push_rec, root_rec;

  function automatic node_rec_t enter_rec(node_rec_t r, logic pv, logic [NW-1:0] par,
                                          logic [WS-1:0] w, logic [DW-1:0] fr);
    node_rec_t e;
    e        = r;
    e.vis    = 1'b1;
    e.pv     = pv;
    e.parent = par;
    e.upw    = w;
    e.fr     = fr;
    e.hi     = fr;
    e.lo     = '0;
    e.climb  = '0;
    e.cv     = r.hv;
    e.cursor = r.head;
    return e;
  endfunction

  assign a32  = 32'(item.node_a);
  assign b32  = 32'(item.node_b);
  assign w32  = 32'(item.weight);
  assign nc32 = 32'(node_count);
  assign n32  = (nc32 == 32'd0) ? 32'd1 : (nc32 > 32'(MAX_NODES)) ? 32'(MAX_NODES) : nc32;
  assign a_id = a32[NW-1:0];
  assign b_id = b32[NW-1:0];
  assign add_drop = (a32 >= 32'(MAX_NODES)) || (b32 >= 32'(MAX_NODES));
  assign add_full = (32'(edge_total) + 32'd2) > 32'(EDGE_CAP);

  assign from_id = side ? add_b : add_a;
  assign to_id   = side ? add_a : add_b;

  always_comb begin
    add_rec      = nrd;
    add_rec.hv   = 1'b1;
    add_rec.tail = edge_total[EW-1:0];
    if (!nrd.hv) begin
      add_rec.head = edge_total[EW-1:0];
    end
  end

  assign pair_sum  = cur.hi + cur.lo;
  assign best_next = (pair_sum > best) ? pair_sum : best;
  assign best64    = 64'(best_next);

  // Length of the longest path from the parent down through the current node.
  assign up_len = cur.climb + DW'(cur.upw);

  always_comb begin
    pop_rec = nrd;
    if (up_len > nrd.lo) begin
      if (up_len > nrd.hi) begin
        pop_rec.lo = nrd.hi;
        pop_rec.hi = up_len;
      end else begin
        pop_rec.lo = up_len;
      end
    end
    if (up_len > nrd.climb) begin
      pop_rec.climb = up_len;
    end
  end

  assign push_rec = enter_rec(nrd, 1'b1, v, ew, cur.fr + DW'(ew));
  assign root_rec = enter_rec(nrd, 1'b0, '0, '0, '0);

  assign item.ready      = (state == S_IDLE);
  assign cfg.ready       = 1'b1;
  assign result.valid    = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_idx    <= '0;
      edge_total <= '0;
      ovf        <= 1'b0;
      out_valid  <= 1'b0;
      node_count <= wtd_pkg::COUNT_W'(1);
      side       <= 1'b0;
      best       <= '0;
    end else begin
      if (cfg.valid) begin
        node_count <= cfg.data;
      end
      if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          nmem[clr_idx] <= '0;
          clr_idx       <= clr_idx + NW'(1);
          if (clr_idx == LAST_NODE) begin
            state      <= S_IDLE;
            edge_total <= '0;
            ovf        <= 1'b0;
          end
        end
        S_IDLE: begin
          if (item.valid) begin
            if (item.mode == wtd_pkg::MODE_FINISH) begin
              best  <= '0;
              nrd   <= nmem[0];
              state <= S_ROOT_WR;
            end else if (add_drop) begin
              state <= S_IDLE;
            end else if (add_full) begin
              ovf <= 1'b1;
            end else begin
              add_a <= a_id;
              add_b <= b_id;
              add_w <= w32[WS-1:0];
              side  <= 1'b0;
              nrd   <= nmem[a_id];
              state <= S_ADD_WR;
            end
          end
        end
        S_ADD_WR: begin
          emem[edge_total[EW-1:0]] <= '{node: to_id, w: add_w, lv: 1'b0, link: '0};
          nmem[from_id] <= add_rec;
          old_hv        <= nrd.hv;
          old_tail      <= nrd.tail;
          state         <= S_ADD_LINK;
        end
        S_ADD_LINK: begin
          if (old_hv) begin
            emem[old_tail].lv   <= 1'b1;
            emem[old_tail].link <= edge_total[EW-1:0];
          end
          edge_total <= edge_total + (EW+1)'(1);
          if (!side) begin
            side  <= 1'b1;
            nrd   <= nmem[add_b];
            state <= S_ADD_WR;
          end else begin
            state <= S_IDLE;
          end
        end
        S_ROOT_WR: begin
          nmem[0] <= root_rec;
          cur     <= root_rec;
          v       <= '0;
          state   <= S_STEP;
        end
        S_STEP: begin
          if (!cur.cv) begin
            best <= best_next;
            if (!cur.pv) begin
              // The root has run out of entries: the walk is over.
              if (!out_valid || result.ready) begin
                out_valid       <= 1'b1;
                result.diameter <= (best64 > 64'hFFFF_FFFF) ? '1 : best64[31:0];
                result.status   <= ovf ? wtd_pkg::STATUS_DROPPED : wtd_pkg::STATUS_OK;
                clr_idx         <= '0;
                state           <= S_CLR;
              end
            end else begin
              nrd   <= nmem[cur.parent];
              state <= S_POP;
            end
          end else begin
            erd   <= emem[cur.cursor];
            state <= S_EDGE;
          end
        end
        S_EDGE: begin
          if (32'(erd.node) < n32) begin
            nrd   <= nmem[erd.node];
            eu    <= erd.node;
            ew    <= erd.w;
            elv   <= erd.lv;
            elink <= erd.link;
            state <= S_CHK;
          end else begin
            cur.cv     <= erd.lv;
            cur.cursor <= erd.link;
            state      <= S_STEP;
          end
        end
        S_CHK: begin
          if (nrd.vis) begin
            cur.cv     <= elv;
            cur.cursor <= elink;
            state      <= S_STEP;
          end else begin
            // The parent is saved with its cursor already past this entry.
            nmem[v]   <= '{hv: cur.hv, head: cur.head, tail: cur.tail, vis: cur.vis,
                           pv: cur.pv, parent: cur.parent, upw: cur.upw, fr: cur.fr,
                           hi: cur.hi, lo: cur.lo, climb: cur.climb, cv: elv,
                           cursor: elink};
            cur       <= push_rec;
            v         <= eu;
            state     <= S_PUSH;
          end
        end
        S_PUSH: begin
          nmem[v] <= cur;
          state   <= S_STEP;
        end
        S_POP: begin
          cur   <= pop_rec;
          v     <= cur.parent;
          state <= S_STEP;
        end
        default: begin
          state <= S_CLR;
        end
      endcase
    end
  end

  a_edge_bound: assert property (@(posedge clk) disable iff (rst)
    32'(edge_total) <= 32'(EDGE_CAP))
    else $error("edge count beyond store capacity");

  a_finish_start: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready && item.mode == wtd_pkg::MODE_FINISH) |=> state == S_ROOT_WR)
    else $error("finish transfer did not start the walk");

  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR && clr_idx == LAST_NODE) |=> (state == S_IDLE && edge_total == '0 && !ovf))
    else $error("clearing pass did not restore an empty problem");

  a_add_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADD_LINK && side) |=> state == S_IDLE)
    else $error("edge load did not finish after its second entry");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_STEP)
    else $error("result raised outside the walk");

endmodule

[verif/tb_weighted_tree_diameter.sv]
// Self-checking testbench for the weighted tree diameter block.
`timescale 1ns / 100ps

module tb_weighted_tree_diameter;

  localparam int NODES    = 4096;
  localparam int EDGE_CAP = 2 * (NODES - 1);
  localparam int NO_EDGE  = -1;
  localparam int IDLE_LIMIT = 200000;
  localparam logic KIND_ITEM = 1'b0;
  localparam logic KIND_CFG  = 1'b1;

  typedef struct packed {
    logic [wtd_pkg::DIAM_W-1:0]   diameter;
    logic [wtd_pkg::STATUS_W-1:0] status;
  } diam_result_t;

  typedef struct {
    logic                         kind;
    logic [wtd_pkg::COUNT_W-1:0]  count;
    logic [wtd_pkg::MODE_W-1:0]   mode;
    logic [wtd_pkg::NODE_W-1:0]   a;
    logic [wtd_pkg::NODE_W-1:0]   b;
    logic [wtd_pkg::WEIGHT_W-1:0] w;
    bit                           typed;
    diam_result_t                 want;
  } stim_row_t;

  logic clk;
  logic rst;

  wtd_item_if   item();
  wtd_result_if result();
  wtd_cfg_if    cfg();

  weighted_tree_diameter DUT (
    .clk(clk), .rst(rst), .item(item.sink), .result(result.source), .cfg(cfg.sink)
  );

  // Predictor state.
  int                  adj_node [EDGE_CAP];
  int                  adj_w    [EDGE_CAP];
  int                  adj_next [EDGE_CAP];
  int                  head     [NODES];
  int                  tail     [NODES];
  bit                  seen     [NODES];
  longint unsigned     top1     [NODES];
  longint unsigned     top2     [NODES];
  longint unsigned     root_dist [NODES];
  longint unsigned     down     [NODES];
  int                  cursor   [NODES];
  int                  path     [NODES];
  int                  path_len;
  int                  entry_count;
  bit                  store_overflow;
  logic [wtd_pkg::COUNT_W-1:0] node_limit;

  diam_result_t pending_diameters[$];
  int  error_count;
  int  edges_sent;
  int  finishes_sent;
  int  results_checked;
  int  idle_cycles;
  bit  calm;
  int  ready_hold;

  function automatic void clear_tree();
    for (int i = 0; i < NODES; i++) begin
      head[i] = NO_EDGE;
      tail[i] = NO_EDGE;
      seen[i] = 1'b0;
    end
    entry_count = 0;
    store_overflow = 1'b0;
  endfunction

  function automatic void link_entry(int from, int to, int w);
    adj_node[entry_count] = to;
    adj_w[entry_count] = w;
    adj_next[entry_count] = NO_EDGE;
    if (tail[from] == NO_EDGE) head[from] = entry_count;
    else adj_next[tail[from]] = entry_count;
    tail[from] = entry_count;
    entry_count++;
  endfunction

  function automatic void load_edge(int a, int b, int w);
    if (entry_count + 2 > EDGE_CAP) begin
      store_overflow = 1'b1;
    end else begin
      link_entry(a, b, w);
      link_entry(b, a, w);
    end
  endfunction

  function automatic void open_node(int v, longint unsigned d);
    seen[v] = 1'b1;
    root_dist[v] = d;
    top1[v] = d;
    top2[v] = 0;
    down[v] = 0;
    cursor[v] = head[v];
    path[path_len] = v;
    path_len++;
  endfunction

  function automatic diam_result_t solve_tree();
    diam_result_t r;
    int n, v, e, u, p, pe;
    longint unsigned best, c;
    n = int'(node_limit);
    if (n < 1) n = 1;
    if (n > NODES) n = NODES;
    best = 0;
    path_len = 0;
    open_node(0, 0);
    while (path_len > 0) begin
      v = path[path_len-1];
      e = cursor[v];
      if (e == NO_EDGE) begin
        if (top1[v] + top2[v] > best) best = top1[v] + top2[v];
        path_len--;
        if (path_len > 0) begin
          p = path[path_len-1];
          pe = cursor[p];
          c = down[v] + adj_w[pe];
          if (c > top2[p]) begin
            if (c > top1[p]) begin
              top2[p] = top1[p];
              top1[p] = c;
            end else begin
              top2[p] = c;
            end
          end
          if (c > down[p]) down[p] = c;
          cursor[p] = adj_next[pe];
        end
      end else begin
        u = adj_node[e];
        if (u < n && !seen[u]) open_node(u, root_dist[v] + adj_w[e]);
        else cursor[v] = adj_next[e];
      end
    end
    r.diameter = (best > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : best[31:0];
    r.status = store_overflow ? wtd_pkg::STATUS_DROPPED : wtd_pkg::STATUS_OK;
    clear_tree();
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One transfer on the item channel; prediction happens at the accepting edge.
  // Valid stays high afterwards so that a following item can come without a gap.
  task automatic send_item(logic [wtd_pkg::MODE_W-1:0] m, int a, int b, int w,
                           bit typed, diam_result_t want);
    diam_result_t r;
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      item.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item.valid  <= 1'b1;
    item.mode   <= m;
    item.node_a <= wtd_pkg::NODE_W'(a);
    item.node_b <= wtd_pkg::NODE_W'(b);
    item.weight <= wtd_pkg::WEIGHT_W'(w);
    do @(posedge clk); while (!item.ready);
    if (m == wtd_pkg::MODE_ADD) begin
      load_edge(a, b, w);
      edges_sent++;
    end else begin
      r = solve_tree();
      pending_diameters.insert(pending_diameters.size(), typed ? want : r);
      finishes_sent++;
    end
  endtask

  task automatic stop_items();
    @(negedge clk);
    item.valid <= 1'b0;
  endtask

  task automatic write_count(logic [wtd_pkg::COUNT_W-1:0] value);
    stop_items();
    wait (pending_diameters.size() == 0);
    repeat (40) @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    node_limit = value;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      result.ready <= 1'b0;
      ready_hold <= $urandom_range(0, 7);
    end else begin
      result.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    diam_result_t want;
    if (!rst && result.valid && result.ready) begin
      if (pending_diameters.size() == 0) begin
        $display("unexpected result diameter %0d at %0t", result.diameter, $realtime);
        error_count++;
      end else begin
        want = pending_diameters.pop_front();
        if (result.diameter !== want.diameter)
          report_mismatch("diameter", 64'(result.diameter), 64'(want.diameter));
        if (result.status !== want.status)
          report_mismatch("status", 64'(result.status), 64'(want.status));
        results_checked++;
      end
    end
  end

  // Watchdog on cycles with no transfer of any kind.
  always @(posedge clk) begin
    if ((item.valid && item.ready) || (result.valid && result.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired, %0d results outstanding", pending_diameters.size());
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic stim_row_t item_row(logic [wtd_pkg::MODE_W-1:0] m, int a, int b, int w);
    stim_row_t s;
    s = '{kind: KIND_ITEM, count: '0, mode: m, a: wtd_pkg::NODE_W'(a),
          b: wtd_pkg::NODE_W'(b), w: wtd_pkg::WEIGHT_W'(w), typed: 0, want: '0};
    return s;
  endfunction

  function automatic stim_row_t cfg_row(int value);
    stim_row_t s;
    s = '{kind: KIND_CFG, count: wtd_pkg::COUNT_W'(value), mode: wtd_pkg::MODE_ADD,
          a: '0, b: '0, w: '0, typed: 0, want: '0};
    return s;
  endfunction

  function automatic stim_row_t typed_finish(int d, logic [wtd_pkg::STATUS_W-1:0] st);
    stim_row_t s;
    s = item_row(wtd_pkg::MODE_FINISH, 0, 0, 0);
    s.typed = 1;
    s.want = '{diameter: d, status: st};
    return s;
  endfunction

  initial begin
    stim_row_t rows[$];
    diam_result_t none;
    int label[64];
    int k, parent, w, drain;
    none = '0;
    error_count = 0;
    edges_sent = 0;
    finishes_sent = 0;
    results_checked = 0;
    idle_cycles = 0;
    ready_hold = 0;
    calm = 0;
    node_limit = 1;
    clear_tree();
    rst = 1'b1;
    item.valid = 1'b0;
    item.mode = wtd_pkg::MODE_ADD;
    item.node_a = '0;
    item.node_b = '0;
    item.weight = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    result.ready = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table: reset count, the walk barrier, extremes, loops and repeats.
    rows.insert(rows.size(), typed_finish(0, wtd_pkg::STATUS_OK));
    rows.insert(rows.size(), item_row(wtd_pkg::MODE_ADD, 0, 1, 5));
    rows.insert(rows.size(), typed_finish(0, wtd_pkg::STATUS_OK));
    rows.insert(rows.size(), cfg_row(4096));
    rows.insert(rows.size(), item_row(wtd_pkg::MODE_ADD, 0, 1, 65535));
    rows.insert(rows.size(), item_row(wtd_pkg::MODE_ADD, 1, 4095, 65535));
    rows.insert(rows.size(), typed_finish(131070, wtd_pkg::STATUS_OK));
    rows.insert(rows.size(), item_row(wtd_pkg::MODE_ADD, 0, 1, 0));
    rows.insert(rows.size(), item_row(wtd_pkg::MODE_ADD, 2, 2, 7));
    rows.insert(rows.size(), item_row(wtd_pkg::MODE_ADD, 0, 2, 9));
    rows.insert(rows.size(), item_row(wtd_pkg::MODE_ADD, 1, 0, 3));
    rows.insert(rows.size(), item_row(wtd_pkg::MODE_ADD, 2, 3, 100));
    rows.insert(rows.size(), item_row(wtd_pkg::MODE_ADD, 3, 1, 40));
    rows.insert(rows.size(), item_row(wtd_pkg::MODE_FINISH, 0, 0, 0));
    rows.insert(rows.size(), cfg_row(3));
    rows.insert(rows.size(), item_row(wtd_pkg::MODE_ADD, 0, 1, 10));
    rows.insert(rows.size(), item_row(wtd_pkg::MODE_ADD, 1, 2, 20));
    rows.insert(rows.size(), item_row(wtd_pkg::MODE_ADD, 2, 3, 30));
    rows.insert(rows.size(), typed_finish(30, wtd_pkg::STATUS_OK));
    rows.insert(rows.size(), cfg_row(0));
    rows.insert(rows.size(), item_row(wtd_pkg::MODE_ADD, 0, 1, 10));
    rows.insert(rows.size(), typed_finish(0, wtd_pkg::STATUS_OK));
    rows.insert(rows.size(), cfg_row(8191));
    rows.insert(rows.size(), item_row(wtd_pkg::MODE_ADD, 4095, 0, 12));
    rows.insert(rows.size(), item_row(wtd_pkg::MODE_FINISH, 0, 0, 0));
    foreach (rows[i]) begin
      if (rows[i].kind == KIND_CFG) write_count(rows[i].count);
      else send_item(rows[i].mode, int'(rows[i].a), int'(rows[i].b), int'(rows[i].w),
                     rows[i].typed, rows[i].want);
    end

    // Random trees with random labels, weights and some noise edges.
    while (edges_sent + finishes_sent < 1650) begin
      calm = (edges_sent + finishes_sent > 1450) || ($urandom_range(0, 5) == 0);
      k = $urandom_range(1, 40);
      label[0] = 0;
      for (int i = 1; i < k; i++)
        label[i] = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095) : i;
      case ($urandom_range(0, 3))
        0: write_count(wtd_pkg::COUNT_W'($urandom_range(0, 8191)));
        1: write_count(wtd_pkg::COUNT_W'($urandom_range(1, k)));
        default: write_count(wtd_pkg::COUNT_W'(k + $urandom_range(0, 3)));
      endcase
      for (int i = 1; i < k; i++) begin
        parent = $urandom_range(0, i - 1);
        case ($urandom_range(0, 5))
          0: w = 0;
          1: w = 65535;
          default: w = $urandom_range(0, 65535);
        endcase
        if ($urandom_range(0, 1))
          send_item(wtd_pkg::MODE_ADD, label[parent], label[i], w, 0, none);
        else
          send_item(wtd_pkg::MODE_ADD, label[i], label[parent], w, 0, none);
        if ($urandom_range(0, 9) == 0)
          send_item(wtd_pkg::MODE_ADD, $urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(0, 65535), 0, none);
      end
      send_item(wtd_pkg::MODE_FINISH, $urandom_range(0, 4095), $urandom_range(0, 4095),
                $urandom_range(0, 65535), 0, none);
    end

    stop_items();
    calm = 1;
    drain = 0;
    while (pending_diameters.size() != 0 && drain < IDLE_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (50) @(posedge clk);
    $display("covered %0d edge transfers and %0d finishes, %0d results checked",
             edges_sent, finishes_sent, results_checked);
    $display("including unreachable nodes, repeated edges, stalls and node counts 0 to 8191");
    if (error_count == 0 && pending_diameters.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
